>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// cond must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> rtl/dllm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dllm_pkg;

    localparam int POOL_NODES_DEF = 32;
    localparam int DATA_WIDTH_DEF = 32;

    // port field widths
    localparam int OP_W     = 2;
    localparam int NODE_W   = 5;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    localparam logic [OP_W-1:0] OP_INS_AFTER  = 2'd0;
    localparam logic [OP_W-1:0] OP_INS_BEFORE = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE     = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR      = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_HANDLE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POOL_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd3;

    typedef struct packed {
        logic load;      // latch the input beat, read the node's links
        logic exec;      // check, allocate/free, first link writes
        logic link;      // second link writes of an insert
        logic out_load;  // capture the result beat
    } dllm_cmd_t;

    typedef struct packed {
        logic two_step;  // current operation needs the second link pass
    } dllm_sts_t;

endpackage

`default_nettype wire

>>> rtl/dllm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dllm_ctrl
    import dllm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    output dllm_cmd_t      cmd,
    input  wire dllm_sts_t sts
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LINK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.load     = accept;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.two_step ? S_LINK : S_DONE;
            end
            S_LINK:
            begin
                cmd.link   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // result waits here until the output register frees up
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_reg || !out_stall, "result beat overwritten while stalled")
    `ASSERT_NEXT(a_accept_exec, clk, rst_n, accept, state_reg == S_EXEC, "accepted beat did not start execution")
    `ASSERT_NEXT(a_link_done, clk, rst_n, state_reg == S_LINK, state_reg == S_DONE && !in_stall == 1'b0, "link pass not followed by result")

endmodule

`default_nettype wire

>>> rtl/dllm_dp.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dllm_dp
    import dllm_pkg::*;
#(
    parameter int POOL_NODES = POOL_NODES_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dllm_cmd_t           cmd,
    output dllm_sts_t                sts,
    input  wire logic [OP_W-1:0]     operation,
    input  wire logic                has_node,
    input  wire logic [NODE_W-1:0]   node,
    input  wire logic [WORD_W-1:0]   data_in,
    output logic [STATUS_W-1:0]      status,
    output logic [NODE_W-1:0]        new_node,
    output logic [WORD_W-1:0]        removed_data,
    output logic [COUNT_W-1:0]       count,
    output logic [NODE_W-1:0]        head_node,
    output logic [NODE_W-1:0]        tail_node,
    output logic                     list_empty
);

    localparam int IDX_W = $clog2(POOL_NODES);
    localparam int LNK_W = $clog2(POOL_NODES + 1);
    localparam logic [LNK_W-1:0] NO_LINK = LNK_W'(POOL_NODES);

    // link and data stores, no reset
    logic [LNK_W-1:0]      next_mem [POOL_NODES];
    logic [LNK_W-1:0]      prev_mem [POOL_NODES];
    logic [DATA_WIDTH-1:0] data_mem [POOL_NODES];

    logic [LNK_W-1:0]      nxt_rd_reg;
    logic [LNK_W-1:0]      prv_rd_reg;
    logic [DATA_WIDTH-1:0] dat_rd_reg;

    logic                  nxt_we, prv_we, dat_we;
    logic [IDX_W-1:0]      nxt_wa, prv_wa, dat_wa;
    logic [LNK_W-1:0]      nxt_wd, prv_wd;

    // latched input beat
    logic [OP_W-1:0]       op_reg;
    logic                  has_reg;
    logic                  rng_reg;
    logic [IDX_W-1:0]      ref_reg;
    logic [DATA_WIDTH-1:0] din_reg;

    logic [IDX_W-1:0]      rd_idx;
    logic                  in_rng;

    // list state
    logic [POOL_NODES-1:0] alloc_reg, alloc_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [IDX_W-1:0]      tail_reg, tail_next;
    logic [LNK_W-1:0]      cnt_reg, cnt_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic                  full_reg, full_next;

    // per-operation results
    logic [STATUS_W-1:0]   status_reg;
    logic [IDX_W-1:0]      new_reg;
    logic [DATA_WIDTH-1:0] removed_reg;

    // output beat
    logic [STATUS_W-1:0]   out_status_reg;
    logic [NODE_W-1:0]     out_new_reg;
    logic [WORD_W-1:0]     out_removed_reg;
    logic [COUNT_W-1:0]    out_count_reg;
    logic [NODE_W-1:0]     out_head_reg;
    logic [NODE_W-1:0]     out_tail_reg;
    logic                  out_empty_reg;

    logic                  is_ins, nonempty, live, ok;
    logic [STATUS_W-1:0]   st;

    assign rd_idx = IDX_W'(node);
    assign in_rng = (32'(node) < 32'(POOL_NODES));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            nxt_rd_reg <= next_mem[rd_idx];
            prv_rd_reg <= prev_mem[rd_idx];
            dat_rd_reg <= data_mem[rd_idx];
            op_reg     <= operation;
            has_reg    <= has_node;
            rng_reg    <= in_rng;
            ref_reg    <= rd_idx;
            din_reg    <= DATA_WIDTH'(data_in);
        end
    end

    always_ff @(posedge clk)
    begin
        if (nxt_we)
        begin
            next_mem[nxt_wa] <= nxt_wd;
        end
        if (prv_we)
        begin
            prev_mem[prv_wa] <= prv_wd;
        end
        if (dat_we)
        begin
            data_mem[dat_wa] <= din_reg;
        end
    end

    // lowest free index, registered; settles well before the next operation
    always_comb
    begin
        free_idx_next = '0;
        full_next     = 1'b1;
        for (int i = POOL_NODES - 1; i >= 0; i--)
        begin
            if (!alloc_reg[i])
            begin
                free_idx_next = IDX_W'(i);
                full_next     = 1'b0;
            end
        end
    end

    assign is_ins   = (op_reg == OP_INS_AFTER) || (op_reg == OP_INS_BEFORE);
    assign nonempty = (cnt_reg != '0);
    assign live     = rng_reg && alloc_reg[ref_reg];

    always_comb
    begin
        st = ST_OK;
        unique case (op_reg) inside
            OP_INS_AFTER, OP_INS_BEFORE:
            begin
                if (!has_reg && nonempty)
                begin
                    st = ST_NO_HANDLE;
                end
                else if (full_reg)
                begin
                    st = ST_POOL_FULL;
                end
                else if (nonempty && !live)
                begin
                    st = ST_NOT_ALLOC;
                end
            end
            OP_REMOVE:
            begin
                if (!has_reg || !nonempty)
                begin
                    st = ST_NO_HANDLE;
                end
                else if (!live)
                begin
                    st = ST_NOT_ALLOC;
                end
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    assign ok           = (st == ST_OK);
    assign sts.two_step = ok && is_ins && nonempty;

    always_comb
    begin
        alloc_next = alloc_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cnt_next   = cnt_reg;
        nxt_we     = 1'b0;
        prv_we     = 1'b0;
        dat_we     = 1'b0;
        nxt_wa     = '0;
        prv_wa     = '0;
        dat_wa     = '0;
        nxt_wd     = '0;
        prv_wd     = '0;
        if (cmd.exec && ok)
        begin
            unique case (op_reg) inside
                OP_INS_AFTER, OP_INS_BEFORE:
                begin
                    alloc_next[free_idx_reg] = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    dat_we   = 1'b1;
                    dat_wa   = free_idx_reg;
                    nxt_we   = 1'b1;
                    nxt_wa   = free_idx_reg;
                    prv_we   = 1'b1;
                    prv_wa   = free_idx_reg;
                    if (!nonempty)
                    begin
                        nxt_wd    = NO_LINK;
                        prv_wd    = NO_LINK;
                        head_next = free_idx_reg;
                        tail_next = free_idx_reg;
                    end
                    else if (op_reg == OP_INS_AFTER)
                    begin
                        nxt_wd = nxt_rd_reg;
                        prv_wd = LNK_W'(ref_reg);
                        if (nxt_rd_reg == NO_LINK)
                        begin
                            tail_next = free_idx_reg;
                        end
                    end
                    else
                    begin
                        prv_wd = prv_rd_reg;
                        nxt_wd = LNK_W'(ref_reg);
                        if (prv_rd_reg == NO_LINK)
                        begin
                            head_next = free_idx_reg;
                        end
                    end
                end
                OP_REMOVE:
                begin
                    alloc_next[ref_reg] = 1'b0;
                    cnt_next = cnt_reg - 1'b1;
                    if (ref_reg == head_reg || prv_rd_reg == NO_LINK)
                    begin
                        if (nxt_rd_reg != NO_LINK)
                        begin
                            head_next = IDX_W'(nxt_rd_reg);
                            prv_we    = 1'b1;
                            prv_wa    = IDX_W'(nxt_rd_reg);
                            prv_wd    = NO_LINK;
                        end
                        else
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                    end
                    else
                    begin
                        nxt_we = 1'b1;
                        nxt_wa = IDX_W'(prv_rd_reg);
                        nxt_wd = nxt_rd_reg;
                        if (nxt_rd_reg != NO_LINK)
                        begin
                            prv_we = 1'b1;
                            prv_wa = IDX_W'(nxt_rd_reg);
                            prv_wd = prv_rd_reg;
                        end
                        else
                        begin
                            tail_next = IDX_W'(prv_rd_reg);
                        end
                    end
                end
                default:
                begin
                    alloc_next = '0;
                    head_next  = '0;
                    tail_next  = '0;
                    cnt_next   = '0;
                end
            endcase
        end
        else if (cmd.link)
        begin
            // hook the new node into its neighbors
            if (op_reg == OP_INS_AFTER)
            begin
                nxt_we = 1'b1;
                nxt_wa = ref_reg;
                nxt_wd = LNK_W'(new_reg);
                if (nxt_rd_reg != NO_LINK)
                begin
                    prv_we = 1'b1;
                    prv_wa = IDX_W'(nxt_rd_reg);
                    prv_wd = LNK_W'(new_reg);
                end
            end
            else
            begin
                prv_we = 1'b1;
                prv_wa = ref_reg;
                prv_wd = LNK_W'(new_reg);
                if (prv_rd_reg != NO_LINK)
                begin
                    nxt_we = 1'b1;
                    nxt_wa = IDX_W'(prv_rd_reg);
                    nxt_wd = LNK_W'(new_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_reg    <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            cnt_reg      <= '0;
            free_idx_reg <= '0;
            full_reg     <= 1'b0;
        end
        else
        begin
            alloc_reg    <= alloc_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            cnt_reg      <= cnt_next;
            free_idx_reg <= free_idx_next;
            full_reg     <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg  <= st;
            new_reg     <= (ok && is_ins) ? free_idx_reg : '0;
            removed_reg <= (ok && op_reg == OP_REMOVE) ? dat_rd_reg : '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg  <= status_reg;
            out_new_reg     <= NODE_W'(new_reg);
            out_removed_reg <= WORD_W'(removed_reg);
            out_count_reg   <= COUNT_W'(cnt_reg);
            out_head_reg    <= nonempty ? NODE_W'(head_reg) : '0;
            out_tail_reg    <= nonempty ? NODE_W'(tail_reg) : '0;
            out_empty_reg   <= !nonempty;
        end
    end

    assign status       = out_status_reg;
    assign new_node     = out_new_reg;
    assign removed_data = out_removed_reg;
    assign count        = out_count_reg;
    assign head_node    = out_head_reg;
    assign tail_node    = out_tail_reg;
    assign list_empty   = out_empty_reg;

    `ASSERT_ALWAYS(a_count_marks, clk, rst_n, $countones(alloc_reg) == cnt_reg, "node count disagrees with allocation marks")
    `ASSERT_IMPLIES(a_empty_ends, clk, rst_n, cnt_reg == '0, head_reg == '0 && tail_reg == '0, "empty list with stale head or tail")
    `ASSERT_IMPLIES(a_head_live, clk, rst_n, cnt_reg != '0, alloc_reg[head_reg] && alloc_reg[tail_reg], "head or tail node not allocated")

endmodule

`default_nettype wire

>>> rtl/doubly_linked_list_manager.sv
// Doubly linked list held in a fixed pool of POOL_NODES nodes; handles are
// pool indices and a new node always takes the lowest free index.
// Input channel (in_valid / in_stall): one beat per operation carrying
// operation, has_node, node and data_in. Output channel (out_valid /
// out_stall): exactly one result beat per operation, in order, with status,
// new_node, removed_data and the count, head and tail after the operation.
// One operation is in flight at a time. An accepted beat goes through the
// exec step, the link step for an insert into a non-empty list, whose
// neighbor links need a second write pass through the single write port of
// each link memory, and then the done step that registers the result. A new
// beat is accepted only after the previous result has been registered.
// While out_stall holds a result, the next operation is still accepted and
// executed; its result waits until the output register is taken, and
// in_stall stays high meanwhile.
// Reset frees every node and empties the list. Link and data memories are
// not cleared; only the links and data of allocated nodes are ever used.
`timescale 1ns / 1ps
`default_nettype none

module doubly_linked_list_manager
    import dllm_pkg::*;
#(
    parameter int POOL_NODES = POOL_NODES_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [OP_W-1:0]     operation,
    input  wire logic                has_node,
    input  wire logic [NODE_W-1:0]   node,
    input  wire logic [WORD_W-1:0]   data_in,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [NODE_W-1:0]        new_node,
    output logic [WORD_W-1:0]        removed_data,
    output logic [COUNT_W-1:0]       count,
    output logic [NODE_W-1:0]        head_node,
    output logic [NODE_W-1:0]        tail_node,
    output logic                     list_empty
);

    dllm_cmd_t cmd;
    dllm_sts_t sts;

    dllm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    dllm_dp #(
        .POOL_NODES (POOL_NODES),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .operation    (operation),
        .has_node     (has_node),
        .node         (node),
        .data_in      (data_in),
        .status       (status),
        .new_node     (new_node),
        .removed_data (removed_data),
        .count        (count),
        .head_node    (head_node),
        .tail_node    (tail_node),
        .list_empty   (list_empty)
    );

endmodule

`default_nettype wire

>>> dv/dll_checker.sv
`timescale 1ns / 1ps

module dll_checker
    import dllm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [OP_W-1:0]     operation,
    input  logic                has_node,
    input  logic [NODE_W-1:0]   node,
    input  logic [WORD_W-1:0]   data_in,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [STATUS_W-1:0] status,
    input  logic [NODE_W-1:0]   new_node,
    input  logic [WORD_W-1:0]   removed_data,
    input  logic [COUNT_W-1:0]  count,
    input  logic [NODE_W-1:0]   head_node,
    input  logic [NODE_W-1:0]   tail_node,
    input  logic                list_empty,
    output int                  fail_count,
    output int                  outstanding
);

    localparam int NODES      = POOL_NODES_DEF;
    localparam int PRINT_CAP  = 40;

    typedef logic [COUNT_W-1:0] link_t;
    localparam link_t NO_LINK = link_t'(NODES);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NODE_W-1:0]   new_node;
        logic [WORD_W-1:0]   removed_data;
        logic [COUNT_W-1:0]  count;
        logic [NODE_W-1:0]   head_node;
        logic [NODE_W-1:0]   tail_node;
        logic                list_empty;
    } list_result_t;

    // shadow of the node pool
    link_t             next_of [NODES];
    link_t             prev_of [NODES];
    logic [WORD_W-1:0] word_of [NODES];
    logic [NODES-1:0]  in_use;
    link_t             head_idx;
    link_t             tail_idx;
    logic [COUNT_W-1:0] list_len;

    list_result_t      awaited_results[$];
    list_result_t      want;
    int                errs = 0;

    function automatic link_t lowest_free();
        link_t idx;
        idx = NO_LINK;
        for (int i = NODES - 1; i >= 0; i--)
            if (!in_use[i])
                idx = link_t'(i);
        return idx;
    endfunction

    function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                   input logic hn,
                                                   input logic [NODE_W-1:0] nd,
                                                   input logic [WORD_W-1:0] dw);
        list_result_t r;
        link_t        n;
        link_t        nb;
        link_t        nx;
        link_t        pv;
        r = '0;
        case (op)
            OP_INS_AFTER, OP_INS_BEFORE:
            begin
                n = lowest_free();
                // check order: missing handle, then pool full, then dead reference
                if (!hn && list_len != 0)
                    r.status = ST_NO_HANDLE;
                else if (n == NO_LINK)
                    r.status = ST_POOL_FULL;
                else if (list_len != 0 && !in_use[nd])
                    r.status = ST_NOT_ALLOC;
                else
                begin
                    in_use[n] = 1'b1;
                    word_of[n] = dw;
                    if (list_len == 0)
                    begin
                        next_of[n] = NO_LINK;
                        prev_of[n] = NO_LINK;
                        head_idx = n;
                        tail_idx = n;
                    end
                    else if (op == OP_INS_AFTER)
                    begin
                        nb = next_of[nd];
                        next_of[n] = nb;
                        prev_of[n] = link_t'(nd);
                        if (nb < NO_LINK)
                            prev_of[nb] = n;
                        else
                            tail_idx = n;
                        next_of[nd] = n;
                    end
                    else
                    begin
                        nb = prev_of[nd];
                        prev_of[n] = nb;
                        next_of[n] = link_t'(nd);
                        if (nb < NO_LINK)
                            next_of[nb] = n;
                        else
                            head_idx = n;
                        prev_of[nd] = n;
                    end
                    list_len++;
                    r.new_node = n[NODE_W-1:0];
                end
            end
            OP_REMOVE:
            begin
                if (!hn || list_len == 0)
                    r.status = ST_NO_HANDLE;
                else if (!in_use[nd])
                    r.status = ST_NOT_ALLOC;
                else
                begin
                    r.removed_data = word_of[nd];
                    nx = next_of[nd];
                    pv = prev_of[nd];
                    if (link_t'(nd) == head_idx || pv >= NO_LINK)
                    begin
                        if (nx < NO_LINK)
                        begin
                            head_idx = nx;
                            prev_of[nx] = NO_LINK;
                        end
                        else
                        begin
                            head_idx = '0;
                            tail_idx = '0;
                        end
                    end
                    else
                    begin
                        next_of[pv] = nx;
                        if (nx < NO_LINK)
                            prev_of[nx] = pv;
                        else
                            tail_idx = pv;
                    end
                    in_use[nd] = 1'b0;
                    list_len--;
                end
            end
            default:
            begin
                // clear: free everything, data words are dropped
                in_use = '0;
                head_idx = '0;
                tail_idx = '0;
                list_len = '0;
            end
        endcase
        r.count = list_len;
        r.list_empty = (list_len == 0);
        r.head_node = r.list_empty ? '0 : head_idx[NODE_W-1:0];
        r.tail_node = r.list_empty ? '0 : tail_idx[NODE_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] wanted);
        if (errs < PRINT_CAP)
            $display("%0t ns: %s: got %0h, want %0h", $time, what, got, wanted);
        errs++;
    endtask

    task automatic check_field(input string field, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] wanted);
        if (got !== wanted)
            report_mismatch(field, got, wanted);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use = '0;
            head_idx = '0;
            tail_idx = '0;
            list_len = '0;
            awaited_results.delete();
            outstanding <= 0;
            fail_count <= errs;
        end
        else
        begin
            // result side first: a beat leaving now belongs to an older operation
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result beat with nothing pending", '0, '0);
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", status, want.status);
                    check_field("new_node", new_node, want.new_node);
                    check_field("removed_data", removed_data, want.removed_data);
                    check_field("count", count, want.count);
                    check_field("head_node", head_node, want.head_node);
                    check_field("tail_node", tail_node, want.tail_node);
                    check_field("list_empty", list_empty, want.list_empty);
                end
            end
            if (in_valid && !in_stall)
                awaited_results.push_back(apply_list_op(operation, has_node, node, data_in));
            outstanding <= awaited_results.size();
            fail_count <= errs;
        end
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dllm_pkg::*;

    localparam int NODES          = POOL_NODES_DEF;
    localparam int ITEMS          = 1650;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic [OP_W-1:0]     operation    = OP_CLEAR;
    logic                has_node     = 1'b0;
    logic [NODE_W-1:0]   node         = '0;
    logic [WORD_W-1:0]   data_in      = '0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   new_node;
    logic [WORD_W-1:0]   removed_data;
    logic [COUNT_W-1:0]  count;
    logic [NODE_W-1:0]   head_node;
    logic [NODE_W-1:0]   tail_node;
    logic                list_empty;

    int fail_count;
    int outstanding;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int sent = 0;
    int quiet_cycles = 0;

    // which pool slots the issued operations leave allocated
    logic [NODES-1:0] live_mask = '0;
    int               live_cnt  = 0;

    always #6 clk = ~clk;

    doubly_linked_list_manager dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .has_node     (has_node),
        .node         (node),
        .data_in      (data_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .new_node     (new_node),
        .removed_data (removed_data),
        .count        (count),
        .head_node    (head_node),
        .tail_node    (tail_node),
        .list_empty   (list_empty)
    );

    dll_checker list_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .has_node     (has_node),
        .node         (node),
        .data_in      (data_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .new_node     (new_node),
        .removed_data (removed_data),
        .count        (count),
        .head_node    (head_node),
        .tail_node    (tail_node),
        .list_empty   (list_empty),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles < WATCHDOG_LIMIT)
            quiet_cycles <= quiet_cycles + 1;
        else
        begin
            $display("doubly_linked_list_manager test failed");
            $finish;
        end
    end

    task automatic track_op(input logic [OP_W-1:0] op, input logic hn,
                            input logic [NODE_W-1:0] nd);
        int slot;
        slot = -1;
        for (int i = NODES - 1; i >= 0; i--)
            if (!live_mask[i])
                slot = i;
        if (op == OP_CLEAR)
        begin
            live_mask = '0;
            live_cnt = 0;
        end
        else if (op == OP_REMOVE)
        begin
            if (hn && live_mask[nd])
            begin
                live_mask[nd] = 1'b0;
                live_cnt--;
            end
        end
        else if (slot >= 0 && (live_cnt == 0 || (hn && live_mask[nd])))
        begin
            live_mask[slot] = 1'b1;
            live_cnt++;
        end
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input logic hn,
                           input logic [NODE_W-1:0] nd, input logic [WORD_W-1:0] dw);
        track_op(op, hn, nd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        has_node  <= hn;
        node      <= nd;
        data_in   <= dw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    // hold the input side until every pending result beat has been taken
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic logic [NODE_W-1:0] pick_node(input logic want_live);
        int start;
        logic [NODE_W-1:0] idx;
        start = $urandom_range(NODES - 1);
        for (int k = 0; k < NODES; k++)
        begin
            idx = NODE_W'((start + k) % NODES);
            if (live_mask[idx] == want_live)
                return idx;
        end
        return NODE_W'(start);
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return '1;
        return $urandom;
    endfunction

    function automatic logic [OP_W-1:0] random_insert();
        return $urandom_range(1) ? OP_INS_AFTER : OP_INS_BEFORE;
    endfunction

    // well-formed edits: inserts around live nodes and removes of live nodes,
    // balanced so the list hovers around half full
    task automatic edit_burst(input int len);
        for (int i = 0; i < len; i++)
        begin
            if (live_cnt == 0)
                send_op(random_insert(), 1'($urandom_range(1)), NODE_W'($urandom),
                        random_word());
            else if ($urandom_range(NODES - 1) < live_cnt)
                send_op(OP_REMOVE, 1'b1, pick_node(1'b1), random_word());
            else
                send_op(random_insert(), 1'b1, pick_node(1'b1), random_word());
        end
    endtask

    task automatic fill_pool();
        while (live_cnt < NODES)
            send_op(random_insert(), 1'b1, pick_node(1'b1), random_word());
        // full pool: a good handle reports full, a missing handle wins over full
        send_op(random_insert(), 1'b1, pick_node(1'b1), random_word());
        send_op(random_insert(), 1'b0, NODE_W'($urandom), random_word());
        if ($urandom_range(1))
            send_op(OP_CLEAR, 1'($urandom_range(1)), NODE_W'($urandom), random_word());
    endtask

    task automatic drain_list();
        while (live_cnt > 0)
            send_op(OP_REMOVE, 1'b1, pick_node(1'b1), random_word());
        send_op(OP_REMOVE, 1'b1, NODE_W'($urandom), random_word());
    endtask

    task automatic noise_burst(input int len);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(1))
                send_op(OP_W'($urandom), 1'($urandom_range(1)), pick_node(1'b0),
                        random_word());
            else
                send_op(OP_W'($urandom), 1'($urandom_range(1)), NODE_W'($urandom),
                        random_word());
        end
    endtask

    task automatic random_sequence();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            edit_burst($urandom_range(20, 5));
        else if (pick < 63)
            fill_pool();
        else if (pick < 72)
            drain_list();
        else if (pick < 76)
            send_op(OP_CLEAR, 1'($urandom_range(1)), NODE_W'($urandom), random_word());
        else
            noise_burst($urandom_range(6, 1));
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 27;
        recv_idle_pct = 56;

        send_op(OP_REMOVE, 1'b1, 5'd0, 32'h0);               // empty list
        send_op(OP_REMOVE, 1'b0, 5'd31, 32'h0);
        send_op(OP_INS_AFTER, 1'b0, 5'd31, 32'h0);           // handle ignored when empty
        send_op(OP_INS_AFTER, 1'b0, 5'd0, 32'h1);            // missing handle
        send_op(OP_INS_BEFORE, 1'b1, 5'd31, 32'h2);          // dead reference
        send_op(OP_INS_AFTER, 1'b1, 5'd0, 32'hFFFF_FFFF);    // new tail
        send_op(OP_INS_BEFORE, 1'b1, 5'd0, 32'hA5A5_A5A5);   // new head
        send_op(OP_INS_BEFORE, 1'b1, 5'd1, 32'h5A5A_5A5A);   // between two nodes
        send_op(OP_INS_AFTER, 1'b1, 5'd2, 32'h0000_0001);
        send_op(OP_REMOVE, 1'b1, 5'd31, 32'h0);              // dead node
        send_op(OP_REMOVE, 1'b0, 5'd0, 32'h0);               // missing handle
        send_op(OP_REMOVE, 1'b1, 5'd0, 32'h0);               // middle
        send_op(OP_REMOVE, 1'b1, 5'd2, 32'h0);               // head
        send_op(OP_REMOVE, 1'b1, 5'd1, 32'h0);               // tail
        send_op(OP_INS_AFTER, 1'b1, 5'd3, 32'h8000_0000);    // reuses lowest slot
        send_op(OP_REMOVE, 1'b1, 5'd2, 32'h0);               // freed earlier
        send_op(OP_CLEAR, 1'b1, 5'd4, 32'hDEAD_BEEF);
        send_op(OP_REMOVE, 1'b1, 5'd0, 32'h0);               // empty after clear
        send_op(OP_INS_BEFORE, 1'b1, 5'd17, 32'h1234_5678);
        send_op(OP_REMOVE, 1'b1, 5'd0, 32'h0);               // last node out
        wait_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 0)
            begin
                send_idle_pct = 27;
                recv_idle_pct = 56;
            end
            else if (ph == 1)
            begin
                send_idle_pct = 56;
                recv_idle_pct = 27;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            while (sent < (ITEMS * (ph + 1)) / 3)
                random_sequence();
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("doubly_linked_list_manager test passed");
        else
            $display("doubly_linked_list_manager test failed");
        $finish;
    end

endmodule
